// ===== rtl/touch_gesture_recognizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Touch gesture recognizer assertion macros
// Shared assertion forms used by the recognizer controller.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_RECOGNIZER_TOP_MACROS_SVH
`define TOUCH_GESTURE_RECOGNIZER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TGR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("touch gesture recognizer check failed");

// The consequent holds in the cycle after the antecedent.
`define TGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch gesture recognizer check failed");

`endif

// ===== rtl/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Shared constants, codes, state and interface types.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;
  localparam int SPEED_W = 23;
  localparam int MS_SCALE = 1000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MOVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_DIST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_VEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DTAP_WINDOW  = 3'd5;

  localparam logic [15:0] RST_HOLD_DELAY   = 16'd500;
  localparam logic [11:0] RST_TAP_MAX_MOVE = 12'd10;
  localparam logic [11:0] RST_DRAG_START   = 12'd12;
  localparam logic [12:0] RST_SWIPE_DIST   = 13'd50;
  localparam logic [22:0] RST_SWIPE_VEL    = 23'd300;
  localparam logic [15:0] RST_DTAP_WINDOW  = 16'd300;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_MOVE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CANCEL  = 2'd3;

  typedef enum logic [2:0] {
    K_HOLD, K_DRAG_BEGIN, K_DRAG_MOVE, K_SWIPE, K_DRAG_END, K_TAP, K_DOUBLE_TAP
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_MUL, ST_DIV, ST_DECIDE, ST_EMIT
  } state_e;

  typedef struct packed {
    logic       sample;
    logic       sq_step;
    logic       root_step;
    logic       mul;
    logic       div_step;
    logic       decide;
    logic       load;
    logic       emit_last;
    logic [1:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic       need_sq;
    logic       need_speed;
    logic       sq_last;
    logic       root_last;
    logic       div_last;
    logic       out_free;
    logic [1:0] rec_cnt;
  } status_t;

endpackage

// ===== rtl/tgr_datapath.sv =====
// ----------------------------------------------------------------------------
// Touch gesture recognizer datapath
// Contact state, configuration, squarer, root and divide units, record slots
// and the output register.
// ----------------------------------------------------------------------------
module tgr_datapath import tgr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [1:0]                   op_i,
  input  logic [COORD_BITS-1:0]        pos_x_i,
  input  logic [COORD_BITS-1:0]        pos_y_i,
  input  logic [TIME_BITS-1:0]         time_ms_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [2:0]                   kind_o,
  output logic [COORD_BITS-1:0]        at_x_o,
  output logic [COORD_BITS-1:0]        at_y_o,
  output logic signed [COORD_BITS:0]   delta_x_o,
  output logic signed [COORD_BITS:0]   delta_y_o,
  output logic [COORD_BITS-1:0]        start_x_o,
  output logic [COORD_BITS-1:0]        start_y_o,
  output logic [SPEED_W-1:0]           speed_o,
  output logic [1:0]                   taps_o,
  output logic                         last_o,
  input  cmd_t                         cmd_i,
  output status_t                      sts_o
);

  localparam int DW   = COORD_BITS + 1;
  localparam int OPW  = (COORD_BITS > 13) ? COORD_BITS : 13;
  localparam int SQW  = 2 * OPW + 1;
  localparam int RW   = OPW + 1;
  localparam int PW   = RW + 10;
  localparam int CNTW = $clog2(PW);
  localparam int TB   = TIME_BITS;

  logic [15:0] cfg_hold_q, cfg_win_q;
  logic [11:0] cfg_tmm_q, cfg_drag_q;
  logic [12:0] cfg_swd_q;
  logic [22:0] cfg_vel_q;

  logic [1:0]            op_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [TB-1:0]         t_q;

  logic                  is_down_q, is_down_d, hold_sent_q, hold_sent_d;
  logic                  dragging_q, dragging_d;
  logic [1:0]            tap_run_q, tap_run_d;
  logic [COORD_BITS-1:0] press_x_q, press_x_d, press_y_q, press_y_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [COORD_BITS-1:0] rel_x_q, rel_x_d, rel_y_q, rel_y_d;
  logic [TB-1:0]         press_time_q, press_time_d, rel_time_q, rel_time_d;

  logic [CNTW-1:0] cnt_q;
  logic [SQW-1:0]  moved2_q, rd2_q, tmm2_q, drag2_q, swipe2_q, win2_q;
  logic [2*RW-1:0] v_q, v_cur;
  logic [RW+1:0]   rem_q, rem_cur;
  logic [RW-1:0]   root_q, root_cur;
  logic [RW+3:0]   rem_sh, trial;
  logic [PW-1:0]   prod_q, dvd_q, dvd_cur;
  logic [TB-1:0]   drem_q, drem_cur, divisor;
  logic [TB:0]     dsh;

  kind_e              rec_kind_q [3];
  kind_e              rec_kind_d [3];
  logic signed [DW-1:0] rec_dx_q [3];
  logic signed [DW-1:0] rec_dx_d [3];
  logic signed [DW-1:0] rec_dy_q [3];
  logic signed [DW-1:0] rec_dy_d [3];
  logic [1:0]         rec_taps_q [3];
  logic [1:0]         rec_taps_d [3];
  logic [1:0]         rec_cnt_q, rec_cnt_d;

  logic signed [DW-1:0] px, py, rx, ry, mdx, mdy;
  logic [DW-1:0]        apx, apy, arx, ary;
  logic [OPW-1:0]       sq_op;
  logic [2*OPW-1:0]     sq;
  logic [TB-1:0]        elapsed, since;
  logic [SPEED_W-1:0]   speed_sat;
  logic                 hold_c, begin_c, drag_now, in_window, step_any, step_last;
  logic [1:0]           tap_now, new_tap, n;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q, out_sx_q, out_sy_q;
  logic signed [DW-1:0]  out_dx_q, out_dy_q;
  logic [SPEED_W-1:0]    out_speed_q;
  logic [1:0]            out_taps_q;
  logic                  out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_hold_q <= RST_HOLD_DELAY;
      cfg_tmm_q  <= RST_TAP_MAX_MOVE;
      cfg_drag_q <= RST_DRAG_START;
      cfg_swd_q  <= RST_SWIPE_DIST;
      cfg_vel_q  <= RST_SWIPE_VEL;
      cfg_win_q  <= RST_DTAP_WINDOW;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HOLD_DELAY:   cfg_hold_q <= cfg_data_i[15:0];
        CFG_TAP_MAX_MOVE: cfg_tmm_q  <= cfg_data_i[11:0];
        CFG_DRAG_START:   cfg_drag_q <= cfg_data_i[11:0];
        CFG_SWIPE_DIST:   cfg_swd_q  <= cfg_data_i[12:0];
        CFG_SWIPE_VEL:    cfg_vel_q  <= cfg_data_i[22:0];
        CFG_DTAP_WINDOW:  cfg_win_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      op_q <= op_i;
      x_q  <= pos_x_i;
      y_q  <= pos_y_i;
      t_q  <= time_ms_i;
    end
  end

  assign px  = $signed({1'b0, x_q}) - $signed({1'b0, press_x_q});
  assign py  = $signed({1'b0, y_q}) - $signed({1'b0, press_y_q});
  assign rx  = $signed({1'b0, x_q}) - $signed({1'b0, rel_x_q});
  assign ry  = $signed({1'b0, y_q}) - $signed({1'b0, rel_y_q});
  assign mdx = $signed({1'b0, x_q}) - $signed({1'b0, prev_x_q});
  assign mdy = $signed({1'b0, y_q}) - $signed({1'b0, prev_y_q});
  assign apx = px[DW-1] ? DW'(-px) : DW'(px);
  assign apy = py[DW-1] ? DW'(-py) : DW'(py);
  assign arx = rx[DW-1] ? DW'(-rx) : DW'(rx);
  assign ary = ry[DW-1] ? DW'(-ry) : DW'(ry);

  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    sq_op = OPW'(apx);
      3'd1:    sq_op = OPW'(apy);
      3'd2:    sq_op = OPW'(arx);
      3'd3:    sq_op = OPW'(ary);
      3'd4:    sq_op = OPW'(cfg_tmm_q);
      3'd5:    sq_op = OPW'(cfg_drag_q);
      3'd6:    sq_op = OPW'(cfg_swd_q);
      default: sq_op = OPW'({cfg_tmm_q, 1'b0});
    endcase
  end
  assign sq = sq_op * sq_op;

  assign step_any  = cmd_i.sq_step | cmd_i.root_step | cmd_i.div_step;
  assign step_last = (cmd_i.sq_step && sts_o.sq_last) || (cmd_i.root_step && sts_o.root_last)
                  || (cmd_i.div_step && sts_o.div_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_any) begin
      cnt_q <= step_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      unique case (cnt_q[2:0])
        3'd0:    moved2_q <= SQW'(sq);
        3'd1:    moved2_q <= moved2_q + SQW'(sq);
        3'd2:    rd2_q    <= SQW'(sq);
        3'd3:    rd2_q    <= rd2_q + SQW'(sq);
        3'd4:    tmm2_q   <= SQW'(sq);
        3'd5:    drag2_q  <= SQW'(sq);
        3'd6:    swipe2_q <= SQW'(sq);
        default: win2_q   <= SQW'(sq);
      endcase
    end
  end

  assign v_cur    = (cnt_q == '0) ? (2*RW)'(moved2_q) : v_q;
  assign rem_cur  = (cnt_q == '0) ? '0 : rem_q;
  assign root_cur = (cnt_q == '0) ? '0 : root_q;
  assign rem_sh   = {rem_cur, v_cur[2*RW-1 -: 2]};
  assign trial    = (RW+4)'({root_cur, 2'b01});

  assign elapsed  = t_q - press_time_q;
  assign since    = t_q - rel_time_q;
  assign divisor  = (elapsed == '0) ? TB'(1) : elapsed;
  assign dvd_cur  = (cnt_q == '0) ? prod_q : dvd_q;
  assign drem_cur = (cnt_q == '0) ? '0 : drem_q;
  assign dsh      = {drem_cur, dvd_cur[PW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_step) begin
      v_q <= v_cur << 2;
      if (rem_sh >= trial) begin
        rem_q  <= (RW+2)'(rem_sh - trial);
        root_q <= {root_cur[RW-2:0], 1'b1};
      end else begin
        rem_q  <= (RW+2)'(rem_sh);
        root_q <= {root_cur[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(root_q) * PW'(MS_SCALE);
    end
    if (cmd_i.div_step) begin
      if (dsh >= {1'b0, divisor}) begin
        drem_q <= TB'(dsh - {1'b0, divisor});
        dvd_q  <= {dvd_cur[PW-2:0], 1'b1};
      end else begin
        drem_q <= TB'(dsh);
        dvd_q  <= {dvd_cur[PW-2:0], 1'b0};
      end
    end
  end

  assign speed_sat = (|dvd_q[PW-1:SPEED_W]) ? SPEED_MAX : dvd_q[SPEED_W-1:0];

  assign hold_c    = !hold_sent_q && (elapsed >= TB'(cfg_hold_q)) && (moved2_q < tmm2_q);
  assign begin_c   = !dragging_q && (moved2_q >= drag2_q);
  assign drag_now  = dragging_q | begin_c;
  assign tap_now   = (hold_c | begin_c) ? 2'd0 : tap_run_q;
  assign in_window = (since <= TB'(cfg_win_q)) && (rd2_q <= win2_q);
  assign new_tap   = in_window ? ((tap_run_q == 2'd3) ? 2'd3 : tap_run_q + 2'd1) : 2'd1;

  always_comb begin
    is_down_d    = is_down_q;
    hold_sent_d  = hold_sent_q;
    dragging_d   = dragging_q;
    tap_run_d    = tap_run_q;
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    press_time_d = press_time_q;
    rel_x_d      = rel_x_q;
    rel_y_d      = rel_y_q;
    rel_time_d   = rel_time_q;
    rec_kind_d   = rec_kind_q;
    rec_dx_d     = rec_dx_q;
    rec_dy_d     = rec_dy_q;
    rec_taps_d   = rec_taps_q;
    rec_cnt_d    = rec_cnt_q;
    n            = 2'd0;
    if (cmd_i.decide) begin
      unique case (op_q)
        OP_PRESS: begin
          is_down_d    = 1'b1;
          press_x_d    = x_q;
          press_y_d    = y_q;
          prev_x_d     = x_q;
          prev_y_d     = y_q;
          press_time_d = t_q;
          hold_sent_d  = 1'b0;
          dragging_d   = 1'b0;
        end
        OP_CANCEL: begin
          is_down_d  = 1'b0;
          dragging_d = 1'b0;
          tap_run_d  = 2'd0;
        end
        OP_MOVE: begin
          if (is_down_q) begin
            if (hold_c) begin
              rec_kind_d[n] = K_HOLD;
              rec_dx_d[n]   = '0;
              rec_dy_d[n]   = '0;
              rec_taps_d[n] = 2'd0;
              n             = n + 2'd1;
            end
            if (begin_c) begin
              rec_kind_d[n] = K_DRAG_BEGIN;
              rec_dx_d[n]   = px;
              rec_dy_d[n]   = py;
              rec_taps_d[n] = 2'd0;
              n             = n + 2'd1;
            end
            if (drag_now) begin
              rec_kind_d[n] = K_DRAG_MOVE;
              rec_dx_d[n]   = mdx;
              rec_dy_d[n]   = mdy;
              rec_taps_d[n] = tap_now;
              n             = n + 2'd1;
            end
            tap_run_d   = tap_now;
            hold_sent_d = hold_sent_q | hold_c;
            dragging_d  = drag_now;
            prev_x_d    = x_q;
            prev_y_d    = y_q;
          end
        end
        OP_RELEASE: begin
          if (is_down_q) begin
            is_down_d = 1'b0;
            if (dragging_q) begin
              rec_kind_d[0] = ((moved2_q >= swipe2_q) && (speed_sat >= cfg_vel_q)) ?
                              K_SWIPE : K_DRAG_END;
              rec_dx_d[0]   = px;
              rec_dy_d[0]   = py;
              rec_taps_d[0] = tap_run_q;
              n             = 2'd1;
              dragging_d    = 1'b0;
            end else begin
              if (moved2_q <= tmm2_q) begin
                rec_dx_d[0]   = '0;
                rec_dy_d[0]   = '0;
                rec_taps_d[0] = new_tap;
                n             = 2'd1;
                if (new_tap >= 2'd2) begin
                  rec_kind_d[0] = K_DOUBLE_TAP;
                  tap_run_d     = 2'd0;
                end else begin
                  rec_kind_d[0] = K_TAP;
                  tap_run_d     = new_tap;
                end
              end else begin
                tap_run_d = 2'd0;
              end
              rel_time_d = t_q;
              rel_x_d    = x_q;
              rel_y_d    = y_q;
            end
          end
        end
        default: ;
      endcase
      rec_cnt_d = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_down_q    <= 1'b0;
      hold_sent_q  <= 1'b0;
      dragging_q   <= 1'b0;
      tap_run_q    <= '0;
      press_x_q    <= '0;
      press_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      press_time_q <= '0;
      rel_x_q      <= '0;
      rel_y_q      <= '0;
      rel_time_q   <= '0;
      rec_cnt_q    <= '0;
    end else begin
      is_down_q    <= is_down_d;
      hold_sent_q  <= hold_sent_d;
      dragging_q   <= dragging_d;
      tap_run_q    <= tap_run_d;
      press_x_q    <= press_x_d;
      press_y_q    <= press_y_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      press_time_q <= press_time_d;
      rel_x_q      <= rel_x_d;
      rel_y_q      <= rel_y_d;
      rel_time_q   <= rel_time_d;
      rec_cnt_q    <= rec_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_kind_q <= rec_kind_d;
    rec_dx_q   <= rec_dx_d;
    rec_dy_q   <= rec_dy_d;
    rec_taps_q <= rec_taps_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_kind_q  <= rec_kind_q[cmd_i.emit_idx];
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_dx_q    <= rec_dx_q[cmd_i.emit_idx];
      out_dy_q    <= rec_dy_q[cmd_i.emit_idx];
      out_sx_q    <= press_x_q;
      out_sy_q    <= press_y_q;
      out_speed_q <= (rec_kind_q[cmd_i.emit_idx] == K_SWIPE ||
                      rec_kind_q[cmd_i.emit_idx] == K_DRAG_END) ? speed_sat : '0;
      out_taps_q  <= rec_taps_q[cmd_i.emit_idx];
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign at_x_o      = out_x_q;
  assign at_y_o      = out_y_q;
  assign delta_x_o   = out_dx_q;
  assign delta_y_o   = out_dy_q;
  assign start_x_o   = out_sx_q;
  assign start_y_o   = out_sy_q;
  assign speed_o     = out_speed_q;
  assign taps_o      = out_taps_q;
  assign last_o      = out_last_q;

  assign sts_o.need_sq    = (op_i == OP_MOVE || op_i == OP_RELEASE) && is_down_q;
  assign sts_o.need_speed = (op_q == OP_RELEASE) && dragging_q;
  assign sts_o.sq_last    = (cnt_q == CNTW'(7));
  assign sts_o.root_last  = (cnt_q == CNTW'(RW - 1));
  assign sts_o.div_last   = (cnt_q == CNTW'(PW - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.rec_cnt    = rec_cnt_q;

endmodule

// ===== rtl/tgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch gesture recognizer controller
// Sequences the squarer, root, scale and divide phases and the record beats.
// ----------------------------------------------------------------------------
`include "touch_gesture_recognizer_top_macros.svh"

module tgr_ctrl import tgr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       last_rec;

  assign last_rec = (idx_q == sts_i.rec_cnt - 2'd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = sts_i.need_sq ? ST_SQ : ST_DECIDE;
      ST_SQ:     if (sts_i.sq_last) state_d = sts_i.need_speed ? ST_ROOT : ST_DECIDE;
      ST_ROOT:   if (sts_i.root_last) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_last) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.rec_cnt == 2'd0) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free && last_rec) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    idx_d      = idx_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:   cmd_o.sample = in_valid_i;
      ST_SQ:     cmd_o.sq_step = 1'b1;
      ST_ROOT:   cmd_o.root_step = 1'b1;
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        idx_d        = 2'd0;
      end
      ST_EMIT: begin
        cmd_o.emit_idx  = idx_q;
        cmd_o.emit_last = last_rec;
        if (sts_i.rec_cnt != 2'd0 && sts_i.out_free) begin
          cmd_o.load = 1'b1;
          idx_d      = idx_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `TGR_ASSERT_NEXT(a_accept_leaves_idle, state_q == ST_IDLE && in_valid_i, state_q != ST_IDLE)
  `TGR_ASSERT_NEXT(a_no_record_to_idle, state_q == ST_EMIT && sts_i.rec_cnt == 2'd0,
                   state_q == ST_IDLE)
  `TGR_ASSERT_IMPL(a_load_has_room, cmd_o.load, sts_i.out_free)

endmodule

// ===== rtl/touch_gesture_recognizer_top.sv =====
// A press, a cancel or an ignored event goes from idle through the decide and emit
// states with the input stalled; a move or a tap release first runs the squarer
// phase; a drag release adds the bit-serial root unit, a scale step and the
// bit-serial divider before its records are decided and emitted.
// A new event is taken only in the idle state, so output stalls also hold the
// input; reset loads register defaults.
// ----------------------------------------------------------------------------
// Touch gesture recognizer top level
// Tap, double tap, hold, drag and swipe detection on a touch event stream.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_top import tgr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [COORD_BITS-1:0]      pos_x_i,
  input  logic [COORD_BITS-1:0]      pos_y_i,
  input  logic [TIME_BITS-1:0]       time_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 kind_o,
  output logic [COORD_BITS-1:0]      at_x_o,
  output logic [COORD_BITS-1:0]      at_y_o,
  output logic signed [COORD_BITS:0] delta_x_o,
  output logic signed [COORD_BITS:0] delta_y_o,
  output logic [COORD_BITS-1:0]      start_x_o,
  output logic [COORD_BITS-1:0]      start_y_o,
  output logic [SPEED_W-1:0]         speed_o,
  output logic [1:0]                 taps_o,
  output logic                       last_o
);

  cmd_t    cmd;
  status_t sts;

  tgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tgr_datapath #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (op_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .time_ms_i   (time_ms_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .at_x_o      (at_x_o),
    .at_y_o      (at_y_o),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o),
    .start_x_o   (start_x_o),
    .start_y_o   (start_y_o),
    .speed_o     (speed_o),
    .taps_o      (taps_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/touch_gesture_recognizer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch gesture recognizer testbench
// Directed events and config writes from a table, then random events with
// random idling, checked against an in-bench predictor or a table record.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_top_tb;
  import tgr_pkg::*;

  localparam int N_RANDOM   = 390;
  localparam int WD_LIMIT   = 3000;
  localparam int LONG_STALL = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [11:0]        at_x;
    logic [11:0]        at_y;
    logic signed [12:0] delta_x;
    logic signed [12:0] delta_y;
    logic [11:0]        start_x;
    logic [11:0]        start_y;
    logic [22:0]        speed;
    logic [1:0]         taps;
    logic               last;
  } gesture_t;

  typedef struct {
    logic [1:0]            op;
    logic [11:0]           x;
    logic [11:0]           y;
    logic [31:0]           t;
    logic                  has_rec;
    gesture_t              rec;
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [1:0] op_i = '0;
  logic [11:0] pos_x_i = '0, pos_y_i = '0;
  logic [31:0] time_ms_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_ready_o, in_stall_o, out_valid_o;
  logic [2:0] kind_o;
  logic [11:0] at_x_o, at_y_o, start_x_o, start_y_o;
  logic signed [12:0] delta_x_o, delta_y_o;
  logic [22:0] speed_o;
  logic [1:0] taps_o;
  logic last_o;

  touch_gesture_recognizer_top DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [63:0] hold_ms, tap_move, drag_dist, swipe_dist, swipe_vel, dtap_ms;
  logic        c_down, c_hold, c_drag;
  logic [11:0] c_px, c_py, c_prx, c_pry, c_rx, c_ry;
  logic [31:0] c_pt, c_rt;
  logic [1:0]  c_taps;

  gesture_t gestures_due[$];
  row_t     rows[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic logic [63:0] sq_dist(longint dx, longint dy);
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
    return r;
  endfunction

  task automatic model_reset();
    hold_ms    = 64'(RST_HOLD_DELAY);
    tap_move   = 64'(RST_TAP_MAX_MOVE);
    drag_dist  = 64'(RST_DRAG_START);
    swipe_dist = 64'(RST_SWIPE_DIST);
    swipe_vel  = 64'(RST_SWIPE_VEL);
    dtap_ms    = 64'(RST_DTAP_WINDOW);
    c_down = 1'b0; c_hold = 1'b0; c_drag = 1'b0;
    c_px = '0; c_py = '0; c_prx = '0; c_pry = '0; c_rx = '0; c_ry = '0;
    c_pt = '0; c_rt = '0; c_taps = '0;
  endtask

  task automatic model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_HOLD_DELAY:   hold_ms    = 64'(val[15:0]);
      CFG_TAP_MAX_MOVE: tap_move   = 64'(val[11:0]);
      CFG_DRAG_START:   drag_dist  = 64'(val[11:0]);
      CFG_SWIPE_DIST:   swipe_dist = 64'(val[12:0]);
      CFG_SWIPE_VEL:    swipe_vel  = 64'(val[22:0]);
      CFG_DTAP_WINDOW:  dtap_ms    = 64'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic push_gesture(kind_e k, logic [11:0] x, logic [11:0] y,
                              longint dx, longint dy, logic [63:0] spd);
    gesture_t g;
    g = '{kind: k, at_x: x, at_y: y, delta_x: dx[12:0], delta_y: dy[12:0],
          start_x: c_px, start_y: c_py, speed: spd[22:0], taps: c_taps, last: 1'b0};
    gestures_due.push_back(g);
  endtask

  task automatic predict_gestures(logic [1:0] op, logic [11:0] x, logic [11:0] y,
                                  logic [31:0] t);
    int n0;
    longint dx, dy;
    logic [63:0] mv2, len, spd, rd2, tm2;
    logic [31:0] elapsed, since;
    bit win;
    n0 = gestures_due.size();
    if (op == OP_PRESS) begin
      c_down = 1'b1; c_px = x; c_py = y; c_prx = x; c_pry = y; c_pt = t;
      c_hold = 1'b0; c_drag = 1'b0;
      return;
    end
    if (op == OP_CANCEL) begin
      c_down = 1'b0; c_drag = 1'b0; c_taps = 2'd0;
      return;
    end
    if (!c_down) return;
    dx = longint'(x) - longint'(c_px);
    dy = longint'(y) - longint'(c_py);
    mv2 = sq_dist(dx, dy);
    elapsed = t - c_pt;
    if (op == OP_MOVE) begin
      if (!c_hold && 64'(elapsed) >= hold_ms && mv2 < tap_move * tap_move) begin
        c_hold = 1'b1; c_taps = 2'd0;
        push_gesture(K_HOLD, x, y, 0, 0, 0);
      end
      if (!c_drag && mv2 >= drag_dist * drag_dist) begin
        c_drag = 1'b1; c_taps = 2'd0;
        push_gesture(K_DRAG_BEGIN, x, y, dx, dy, 0);
      end
      if (c_drag)
        push_gesture(K_DRAG_MOVE, x, y, longint'(x) - longint'(c_prx),
                     longint'(y) - longint'(c_pry), 0);
      c_prx = x; c_pry = y;
    end else begin
      c_down = 1'b0;
      if (c_drag) begin
        len = int_root(mv2);
        spd = len * 1000 / (elapsed == 0 ? 64'd1 : 64'(elapsed));
        if (spd > 64'h7F_FFFF) spd = 64'h7F_FFFF;
        if (mv2 >= swipe_dist * swipe_dist && spd >= swipe_vel)
          push_gesture(K_SWIPE, x, y, dx, dy, spd);
        else
          push_gesture(K_DRAG_END, x, y, dx, dy, spd);
        c_drag = 1'b0;
      end else begin
        since = t - c_rt;
        rd2 = sq_dist(longint'(x) - longint'(c_rx), longint'(y) - longint'(c_ry));
        tm2 = (2 * tap_move) * (2 * tap_move);
        win = 64'(since) <= dtap_ms && rd2 <= tm2;
        if (mv2 <= tap_move * tap_move) begin
          c_taps = win ? (c_taps < 2'd3 ? c_taps + 2'd1 : 2'd3) : 2'd1;
          if (c_taps >= 2'd2) begin
            push_gesture(K_DOUBLE_TAP, x, y, 0, 0, 0);
            c_taps = 2'd0;
          end else begin
            push_gesture(K_TAP, x, y, 0, 0, 0);
          end
        end else begin
          c_taps = 2'd0;
        end
        c_rt = t; c_rx = x; c_ry = y;
      end
    end
    if (gestures_due.size() > n0) gestures_due[$].last = 1'b1;
  endtask

  function automatic row_t ev(logic [1:0] op, logic [11:0] x, logic [11:0] y,
                              logic [31:0] t);
    row_t r;
    r = '{op: op, x: x, y: y, t: t, has_rec: 1'b0, rec: '0, is_cfg: 1'b0,
          cfg_idx: '0, cfg_val: '0};
    return r;
  endfunction

  function automatic row_t ev_rec(logic [1:0] op, logic [11:0] x, logic [11:0] y,
                                  logic [31:0] t, kind_e k, longint dx, longint dy,
                                  logic [11:0] sx, logic [11:0] sy, logic [22:0] spd,
                                  logic [1:0] tp);
    row_t r;
    r = ev(op, x, y, t);
    r.has_rec = 1'b1;
    r.rec = '{kind: k, at_x: x, at_y: y, delta_x: dx[12:0], delta_y: dy[12:0],
              start_x: sx, start_y: sy, speed: spd, taps: tp, last: 1'b1};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = ev(OP_PRESS, '0, '0, '0);
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i); while (in_stall_o || gestures_due.size() != 0);
  endtask

  task automatic send_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_config(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_event(row_t r);
    int n0;
    repeat ($urandom_range(0, 6)) @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i       = r.op;
    pos_x_i    = r.x;
    pos_y_i    = r.y;
    time_ms_i  = r.t;
    do @(posedge clk_i); while (in_stall_o);
    n0 = gestures_due.size();
    predict_gestures(r.op, r.x, r.y, r.t);
    if (r.has_rec) begin
      while (gestures_due.size() > n0) void'(gestures_due.pop_back());
      gestures_due.push_back(r.rec);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    row_t r;
    int k, sel, cx, cy;
    logic [31:0] ct, dt;
    logic [1:0] op;
    logic [CFG_IDX_W-1:0] ci;
    logic [CFG_DATA_W-1:0] cv;
    model_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows.push_back(cfg_row(CFG_HOLD_DELAY, 23'h7F_01F4));
    rows.push_back(cfg_row(CFG_UNUSED, 23'h01_2345));
    rows.push_back(ev(OP_MOVE, 12'd100, 12'd100, 32'd10));
    rows.push_back(ev(OP_RELEASE, 12'd100, 12'd100, 32'd20));
    rows.push_back(ev(OP_PRESS, 12'd100, 12'd100, 32'd1000));
    rows.push_back(ev_rec(OP_RELEASE, 12'd100, 12'd100, 32'd1050, K_TAP, 0, 0,
                          12'd100, 12'd100, 23'd0, 2'd1));
    rows.push_back(ev(OP_PRESS, 12'd102, 12'd100, 32'd1200));
    rows.push_back(ev_rec(OP_RELEASE, 12'd102, 12'd100, 32'd1250, K_DOUBLE_TAP, 0, 0,
                          12'd102, 12'd100, 23'd0, 2'd2));
    rows.push_back(ev(OP_PRESS, 12'd500, 12'd500, 32'd2000));
    rows.push_back(ev_rec(OP_MOVE, 12'd500, 12'd500, 32'd2600, K_HOLD, 0, 0,
                          12'd500, 12'd500, 23'd0, 2'd0));
    rows.push_back(ev(OP_RELEASE, 12'd500, 12'd500, 32'd2700));
    rows.push_back(ev(OP_PRESS, 12'd1000, 12'd1000, 32'd3000));
    rows.push_back(ev(OP_MOVE, 12'd1100, 12'd1000, 32'd3050));
    rows.push_back(ev_rec(OP_RELEASE, 12'd1200, 12'd1000, 32'd3100, K_SWIPE, 200, 0,
                          12'd1000, 12'd1000, 23'd2000, 2'd0));
    rows.push_back(ev(OP_PRESS, 12'd0, 12'd0, 32'd4000));
    rows.push_back(ev(OP_MOVE, 12'd4095, 12'd4095, 32'd4000));
    rows.push_back(ev(OP_RELEASE, 12'd4095, 12'd4095, 32'd4000));
    rows.push_back(ev(OP_PRESS, 12'd10, 12'd10, 32'hFFFF_FFF0));
    rows.push_back(ev(OP_MOVE, 12'd10, 12'd10, 32'h0000_0200));
    rows.push_back(ev(OP_RELEASE, 12'd12, 12'd10, 32'h0000_0210));
    rows.push_back(ev(OP_PRESS, 12'd300, 12'd300, 32'h0000_0300));
    rows.push_back(ev(OP_CANCEL, 12'd300, 12'd300, 32'h0000_0310));
    rows.push_back(ev(OP_RELEASE, 12'd300, 12'd300, 32'h0000_0320));
    rows.push_back(ev(OP_PRESS, 12'd4095, 12'd0, 32'h0000_0400));
    rows.push_back(ev(OP_MOVE, 12'd0, 12'd4095, 32'h0000_0401));
    rows.push_back(ev(OP_RELEASE, 12'd0, 12'd4095, 32'h0000_0402));
    rows.push_back(cfg_row(CFG_SWIPE_VEL, 23'h7F_FFFF));
    rows.push_back(ev(OP_PRESS, 12'd1000, 12'd1000, 32'd5000));
    rows.push_back(ev(OP_MOVE, 12'd1100, 12'd1000, 32'd5050));
    rows.push_back(ev_rec(OP_RELEASE, 12'd1200, 12'd1000, 32'd5100, K_DRAG_END, 200, 0,
                          12'd1000, 12'd1000, 23'd2000, 2'd0));
    rows.push_back(cfg_row(CFG_SWIPE_VEL, CFG_DATA_W'(RST_SWIPE_VEL)));
    rows.push_back(cfg_row(CFG_TAP_MAX_MOVE, 23'd0));
    rows.push_back(ev(OP_PRESS, 12'd50, 12'd50, 32'd6000));
    rows.push_back(ev(OP_RELEASE, 12'd50, 12'd50, 32'd6010));
    rows.push_back(cfg_row(CFG_TAP_MAX_MOVE, CFG_DATA_W'(RST_TAP_MAX_MOVE)));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) send_cfg(rows[i].cfg_idx, rows[i].cfg_val);
      else send_event(rows[i]);
    end

    cx = 2000;
    cy = 2000;
    ct = 32'd10000;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 120) long_hold = 1'b1;
      if (k % 50 == 25) begin
        ci = CFG_IDX_W'($urandom_range(0, 5));
        case (ci)
          CFG_HOLD_DELAY:   cv = CFG_DATA_W'($urandom_range(0, 1000));
          CFG_TAP_MAX_MOVE: cv = CFG_DATA_W'($urandom_range(0, 30));
          CFG_DRAG_START:   cv = CFG_DATA_W'($urandom_range(0, 40));
          CFG_SWIPE_DIST:   cv = CFG_DATA_W'($urandom_range(0, 400));
          CFG_SWIPE_VEL:    cv = CFG_DATA_W'($urandom_range(0, 6000));
          default:          cv = CFG_DATA_W'($urandom_range(0, 600));
        endcase
        send_cfg(ci, cv);
      end
      sel = int'($urandom_range(0, 99));
      if (sel < 25) op = OP_PRESS;
      else if (sel < 65) op = OP_MOVE;
      else if (sel < 95) op = OP_RELEASE;
      else op = OP_CANCEL;
      sel = int'($urandom_range(0, 99));
      if (sel < 55) begin
        cx = cx + int'($urandom_range(0, 16)) - 8;
        cy = cy + int'($urandom_range(0, 16)) - 8;
      end else if (sel < 90) begin
        cx = cx + int'($urandom_range(0, 300)) - 150;
        cy = cy + int'($urandom_range(0, 300)) - 150;
      end else begin
        cx = int'($urandom_range(0, 4095));
        cy = int'($urandom_range(0, 4095));
      end
      if (cx < 0) cx = 0;
      if (cx > 4095) cx = 4095;
      if (cy < 0) cy = 0;
      if (cy > 4095) cy = 4095;
      sel = int'($urandom_range(0, 99));
      if (sel < 10) dt = 32'd0;
      else if (sel < 85) dt = 32'($urandom_range(1, 250));
      else if (sel < 97) dt = 32'($urandom_range(251, 1500));
      else dt = 32'($urandom());
      ct = ct + dt;
      r = ev(op, 12'(cx), 12'(cy), ct);
      send_event(r);
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && gestures_due.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : receiver
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_n = long_hold ? LONG_STALL : int'($urandom_range(0, 6));
      long_hold = 1'b0;
      if (wait_n > 0) begin
        out_stall_i = 1'b1;
        repeat (wait_n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : monitor
    gesture_t got;
    gesture_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind: kind_o, at_x: at_x_o, at_y: at_y_o, delta_x: delta_x_o,
              delta_y: delta_y_o, start_x: start_x_o, start_y: start_y_o,
              speed: speed_o, taps: taps_o, last: last_o};
      if (gestures_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected beat at %0t: got %h", $time, got);
      end else begin
        want = gestures_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected %h, got %h", $time, want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
